>>> hw/rtl/great_circle_distance_defines.svh
// Assertion macros for the great-circle distance block.
// Used by the modules that carry assertions; expects clk and arst_n in scope.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication
`define GCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/gcd_pkg.sv
// Shared constants, types and tables for the great-circle distance block.
// No dependencies.
package gcd_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int SQRT_STEPS    = 31;

	localparam int ANG_W  = 34;
	localparam int MIN_W  = 16;
	localparam int MAG_W  = 14;
	localparam int HI_W   = 53;
	localparam int LO_W   = 45;
	localparam int SUM_W  = 54;
	localparam int A_W    = 31;
	localparam int SQ_W   = 62;
	localparam int Z_W    = 31;
	localparam int RAD_W  = 13;
	localparam int PROD_W = 44;
	localparam int DIST_W = 19;

	localparam int HALF_TURN    = 10800;
	localparam int FULL_TURN    = 21600;
	localparam int QUARTER_TURN = 5400;

	// pi in Q46 split as 675 * PI_DIV_675 + 239; REM_RECIP = 239 * ceil(2^32 / 675)
	localparam logic [38:0] PI_DIV_675 = 39'd327511007038;
	localparam logic [30:0] REM_RECIP  = 31'd1520736685;

	typedef logic signed [ANG_W-1:0] ang_t;

	localparam ang_t CORDIC_GAIN = 34'sh26DD3B6A;
	localparam logic [A_W-1:0] ONE_Q30 = 31'h40000000;

	localparam logic [RAD_W-1:0]  RADIUS_RESET = 13'd6371;
	localparam logic [DIST_W-1:0] DIST_MAX     = 19'h7FFFF;

	typedef logic [31:0] atan_tab_t [32];

	localparam atan_tab_t ATAN_TAB = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [7:0] first_lat_deg;
		logic [5:0]        first_lat_min;
		logic signed [8:0] first_lon_deg;
		logic [5:0]        first_lon_min;
		logic signed [7:0] second_lat_deg;
		logic [5:0]        second_lat_min;
		logic signed [8:0] second_lon_deg;
		logic [5:0]        second_lon_min;
	} pts_t;

endpackage

>>> hw/rtl/gcd_ifs.sv
// Valid/ready channel interfaces: point pair in, distance out, radius write.
// Depends on gcd_pkg.
interface gcd_pts_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] first_lat_deg;
	logic [5:0]        first_lat_min;
	logic signed [8:0] first_lon_deg;
	logic [5:0]        first_lon_min;
	logic signed [7:0] second_lat_deg;
	logic [5:0]        second_lat_min;
	logic signed [8:0] second_lon_deg;
	logic [5:0]        second_lon_min;

	modport source (output valid, first_lat_deg, first_lat_min, first_lon_deg, first_lon_min,
		second_lat_deg, second_lat_min, second_lon_deg, second_lon_min, input ready);
	modport sink (input valid, first_lat_deg, first_lat_min, first_lon_deg, first_lon_min,
		second_lat_deg, second_lat_min, second_lon_deg, second_lon_min, output ready);
endinterface

interface gcd_dist_if;
	logic                        valid;
	logic                        ready;
	logic [gcd_pkg::DIST_W-1:0]  distance_km_q4;

	modport source (output valid, distance_km_q4, input ready);
	modport sink (input valid, distance_km_q4, output ready);
endinterface

interface gcd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [gcd_pkg::RAD_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/great_circle_distance.sv
// Great-circle distance (haversine) between two points, scaled by a sphere radius.
// Depends on gcd_pkg, gcd_ifs, gcd_angle, gcd_cordic_rot, gcd_hav, gcd_isqrt, gcd_cordic_vec.
//
//   channel   modport  transaction
//   points    sink     one pair of points, degrees and minutes
//   distance  source   distance_km_q4, km with 4 fraction bits
//   cfg       sink     sphere radius in km, 13 bits
//
// One transaction in per cycle unless the pipeline stalls; the data passes through the angle front end,
// the two CORDIC pipelines, the haversine stages and the 31-step square root.
// Reset clears all valid bits and loads the radius with 6371.
// A result held at the output stalls the whole pipeline unless the last stage is empty.
`include "great_circle_distance_defines.svh"

module great_circle_distance (
	input  logic  clk,
	input  logic  arst_n,
	gcd_pts_if.sink    points,
	gcd_dist_if.source distance,
	gcd_cfg_if.sink    cfg
);
	localparam int A_W    = gcd_pkg::A_W;
	localparam int Z_W    = gcd_pkg::Z_W;
	localparam int PROD_W = gcd_pkg::PROD_W;
	localparam int ANG_W  = gcd_pkg::ANG_W;

	gcd_pkg::pts_t pts;
	logic          pipe_en, out_ld;

	logic [gcd_pkg::RAD_W-1:0] radius_q;

	logic          ang_vld;
	gcd_pkg::ang_t ang_z [4];
	logic [1:0]    ang_fold;

	logic          rot_vld;
	gcd_pkg::ang_t cos1, cos2, sin_dlat, sin_dlon;

	logic           hav_vld;
	logic [A_W-1:0] hav_a, hav_1a;

	logic           sq_vld;
	logic [A_W-1:0] sq_y, sq_x;

	logic           vec_vld;
	gcd_pkg::ang_t  vec_z;
	logic [Z_W-1:0] z_clip;

	logic              zprod_vld_s1;
	logic [PROD_W-1:0] zprod_s1;
	logic [PROD_W:0]   rnd;
	logic [19:0]       dist_full;

	logic                       out_vld_q;
	logic [gcd_pkg::DIST_W-1:0] out_dist_q;

	assign pts.first_lat_deg  = points.first_lat_deg;
	assign pts.first_lat_min  = points.first_lat_min;
	assign pts.first_lon_deg  = points.first_lon_deg;
	assign pts.first_lon_min  = points.first_lon_min;
	assign pts.second_lat_deg = points.second_lat_deg;
	assign pts.second_lat_min = points.second_lat_min;
	assign pts.second_lon_deg = points.second_lon_deg;
	assign pts.second_lon_min = points.second_lon_min;

	assign out_ld       = !out_vld_q || distance.ready;
	assign pipe_en      = out_ld || !zprod_vld_s1;
	assign points.ready = pipe_en;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else if (cfg.valid) begin
			radius_q <= cfg.data;
		end
	end

	gcd_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (points.valid),
		.pts       (pts),
		.out_valid (ang_vld),
		.z         (ang_z),
		.fold      (ang_fold)
	);

	gcd_cordic_rot u_rot_lat1 (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (ang_vld), .angle (ang_z[0]), .fold (ang_fold[0]),
		.out_valid (rot_vld), .cos_o (cos1), .sin_o ()
	);

	gcd_cordic_rot u_rot_lat2 (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (ang_vld), .angle (ang_z[1]), .fold (ang_fold[1]),
		.out_valid (), .cos_o (cos2), .sin_o ()
	);

	gcd_cordic_rot u_rot_dlat (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (ang_vld), .angle (ang_z[2]), .fold (1'b0),
		.out_valid (), .cos_o (), .sin_o (sin_dlat)
	);

	gcd_cordic_rot u_rot_dlon (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (ang_vld), .angle (ang_z[3]), .fold (1'b0),
		.out_valid (), .cos_o (), .sin_o (sin_dlon)
	);

	gcd_hav u_hav (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (rot_vld),
		.cos1      (cos1),
		.cos2      (cos2),
		.sin_dlat  (sin_dlat),
		.sin_dlon  (sin_dlon),
		.out_valid (hav_vld),
		.a         (hav_a)
	);

	assign hav_1a = gcd_pkg::ONE_Q30 - hav_a;

	gcd_isqrt u_sqrt_a (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (hav_vld), .op (hav_a), .out_valid (sq_vld), .root (sq_y)
	);

	gcd_isqrt u_sqrt_1a (
		.clk (clk), .arst_n (arst_n), .en (pipe_en),
		.in_valid (hav_vld), .op (hav_1a), .out_valid (), .root (sq_x)
	);

	gcd_cordic_vec u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (sq_vld),
		.y0        (sq_y),
		.x0        (sq_x),
		.out_valid (vec_vld),
		.angle     (vec_z)
	);

	assign z_clip    = vec_z[ANG_W-1] ? '0 : vec_z[Z_W-1:0];
	assign rnd       = (PROD_W+1)'(zprod_s1) + ((PROD_W+1)'(1) << 24);
	assign dist_full = rnd[PROD_W:25];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zprod_vld_s1 <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (pipe_en) begin
				zprod_vld_s1 <= vec_vld;
			end
			if (out_ld) begin
				out_vld_q <= zprod_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			zprod_s1 <= PROD_W'(z_clip) * PROD_W'(radius_q);
		end
		if (out_ld) begin
			out_dist_q <= (dist_full > 20'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
				: dist_full[gcd_pkg::DIST_W-1:0];
		end
	end

	assign distance.valid          = out_vld_q;
	assign distance.distance_km_q4 = out_dist_q;

	`GCD_ASSERT_NEXT(a_stall_holds, !pipe_en, zprod_vld_s1 && $stable(zprod_s1), "last stage moved in stall")
	`GCD_ASSERT_NEXT(a_out_loads, out_ld && zprod_vld_s1, out_vld_q, "result dropped at output")

endmodule

>>> hw/rtl/gcd_angle.sv
// Front end: degrees/minutes to arc minutes, wrap, fold, and scaling to Q2.30 radians.
// Depends on gcd_pkg. Three stages; lanes: cos lat1, cos lat2, dlat/2, dlon/2.
module gcd_angle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  gcd_pkg::pts_t       pts,
	output logic                out_valid,
	output gcd_pkg::ang_t       z [4],
	output logic [1:0]          fold
);
	localparam int MIN_W = gcd_pkg::MIN_W;
	localparam int MAG_W = gcd_pkg::MAG_W;
	localparam int HI_W  = gcd_pkg::HI_W;
	localparam int LO_W  = gcd_pkg::LO_W;
	localparam int SUM_W = gcd_pkg::SUM_W;
	localparam int ANG_W = gcd_pkg::ANG_W;

	function automatic logic signed [MIN_W-1:0] to_min(input logic signed [8:0] deg,
		input logic [5:0] mi);
		logic signed [MIN_W-1:0] d;
		logic signed [MIN_W-1:0] m;
		d = MIN_W'(deg) * MIN_W'(60);
		m = $signed(MIN_W'({1'b0, mi}));
		return deg[8] ? d - m : d + m;
	endfunction

	function automatic logic signed [MIN_W-1:0] wrap(input logic signed [MIN_W-1:0] x);
		if (x >= gcd_pkg::HALF_TURN) begin
			return MIN_W'(x - gcd_pkg::FULL_TURN);
		end else if (x < -gcd_pkg::HALF_TURN) begin
			return MIN_W'(x + gcd_pkg::FULL_TURN);
		end
		return x;
	endfunction

	logic signed [MIN_W-1:0] lat1, lat2, lon1, lon2, dlat, dlon;
	logic signed [MIN_W-1:0] ang [4];
	logic [MAG_W-1:0] mag [4];
	logic [3:0]       neg;

	logic [2:0]       vld_s;
	logic [MAG_W-1:0] mag_s1 [4];
	logic [3:0]       neg_s1, neg_s2, neg_s3;
	logic [HI_W-1:0]  hi_s2 [4];
	logic [11:0]      lo_s2 [4];
	gcd_pkg::ang_t    z_s3 [4];

	assign lat1 = to_min(9'(pts.first_lat_deg), pts.first_lat_min);
	assign lon1 = to_min(pts.first_lon_deg, pts.first_lon_min);
	assign lat2 = to_min(9'(pts.second_lat_deg), pts.second_lat_min);
	assign lon2 = to_min(pts.second_lon_deg, pts.second_lon_min);
	assign dlat = wrap(MIN_W'(lat2 - lat1));
	assign dlon = wrap(MIN_W'(lon2 - lon1));

	assign ang[0] = lat1;
	assign ang[1] = lat2;
	assign ang[2] = dlat;
	assign ang[3] = dlon;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			mag[l] = ang[l][MIN_W-1] ? MAG_W'(-ang[l]) : MAG_W'(ang[l]);
			neg[l] = ang[l][MIN_W-1];
			if (l < 2) begin
				neg[l] = 1'b0;
				if (mag[l] > MAG_W'(gcd_pkg::QUARTER_TURN)) begin
					mag[l] = MAG_W'(gcd_pkg::HALF_TURN - int'(mag[l]));
					neg[l] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_valid};
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam int SH = (l < 2) ? 20 : 21;
		logic [SUM_W-1:0] sum;
		logic [ANG_W-1:0] r;

		assign sum = SUM_W'(hi_s2[l]) + SUM_W'(lo_s2[l]) + (SUM_W'(1) << (SH - 1));
		assign r   = ANG_W'(sum >> SH);

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1[l] <= mag[l];
				hi_s2[l]  <= HI_W'(mag_s1[l]) * HI_W'(gcd_pkg::PI_DIV_675);
				lo_s2[l]  <= 12'((LO_W'(mag_s1[l]) * LO_W'(gcd_pkg::REM_RECIP)) >> 32);
				if (l >= 2 && neg_s2[l]) begin
					z_s3[l] <= -$signed(r);
				end else begin
					z_s3[l] <= $signed(r);
				end
			end
		end

		assign z[l] = z_s3[l];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
		end
	end

	assign fold      = neg_s3[1:0];
	assign out_valid = vld_s[2];

endmodule

>>> hw/rtl/gcd_cordic_rot.sv
// Pipelined rotation-mode CORDIC, one stage per iteration; gives cos and sin.
// Depends on gcd_pkg. The fold flag travels along and negates the cosine.
module gcd_cordic_rot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  gcd_pkg::ang_t  angle,
	input  logic           fold,
	output logic           out_valid,
	output gcd_pkg::ang_t  cos_o,
	output gcd_pkg::ang_t  sin_o
);
	localparam int N     = gcd_pkg::CORDIC_STAGES;
	localparam int ANG_W = gcd_pkg::ANG_W;

	logic [N-1:0]  vld_s;
	gcd_pkg::ang_t x_s [N];
	gcd_pkg::ang_t y_s [N];
	gcd_pkg::ang_t z_s [N];
	logic [N-1:0]  f_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam gcd_pkg::ang_t ATAN_I = ANG_W'({2'b00, gcd_pkg::ATAN_TAB[i]});
		gcd_pkg::ang_t x_in, y_in, z_in;
		logic          f_in;

		if (i == 0) begin : g_first
			assign x_in = gcd_pkg::CORDIC_GAIN;
			assign y_in = '0;
			assign z_in = angle;
			assign f_in = fold;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
			assign f_in = f_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i] <= f_in;
				if (!z_in[ANG_W-1]) begin
					x_s[i] <= x_in - (y_in >>> i);
					y_s[i] <= y_in + (x_in >>> i);
					z_s[i] <= z_in - ATAN_I;
				end else begin
					x_s[i] <= x_in + (y_in >>> i);
					y_s[i] <= y_in - (x_in >>> i);
					z_s[i] <= z_in + ATAN_I;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign cos_o     = f_s[N-1] ? -x_s[N-1] : x_s[N-1];
	assign sin_o     = y_s[N-1];

endmodule

>>> hw/rtl/gcd_hav.sv
// Haversine term a = sin^2(dlat/2) + cos(lat1)cos(lat2)sin^2(dlon/2), clamped to [0, 1].
// Depends on gcd_pkg. Four stages; the multipliers sit in the first and third.
module gcd_hav (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  gcd_pkg::ang_t           cos1,
	input  gcd_pkg::ang_t           cos2,
	input  gcd_pkg::ang_t           sin_dlat,
	input  gcd_pkg::ang_t           sin_dlon,
	output logic                    out_valid,
	output logic [gcd_pkg::A_W-1:0] a
);
	localparam int A_W = gcd_pkg::A_W;
	localparam logic signed [63:0] HALF_LSB = 64'sd536870912;
	localparam logic signed [32:0] ONE_S    = 33'sd1073741824;

	logic signed [31:0] c1, c2, s1, s2;
	logic signed [32:0] sum;

	logic [3:0]         vld_s;
	logic signed [63:0] sq_dl_s1, sq_do_s1, cc_s1;
	logic signed [31:0] sdl_s2, sdo_s2, cc_s2, sdl_s3;
	logic signed [63:0] prod_s3;
	logic [A_W-1:0]     a_s4;

	// Q2.30 values stay within +-2^31
	assign c1 = 32'(cos1);
	assign c2 = 32'(cos2);
	assign s1 = 32'(sin_dlat);
	assign s2 = 32'(sin_dlon);

	assign sum = 33'(sdl_s3) + 33'((prod_s3 + HALF_LSB) >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_dl_s1 <= 64'(s1) * 64'(s1);
			sq_do_s1 <= 64'(s2) * 64'(s2);
			cc_s1    <= 64'(c1) * 64'(c2);

			sdl_s2 <= 32'((sq_dl_s1 + HALF_LSB) >>> 30);
			sdo_s2 <= 32'((sq_do_s1 + HALF_LSB) >>> 30);
			cc_s2  <= 32'((cc_s1 + HALF_LSB) >>> 30);

			prod_s3 <= 64'(cc_s2) * 64'(sdo_s2);
			sdl_s3  <= sdl_s2;

			if (sum[32]) begin
				a_s4 <= '0;
			end else if (sum > ONE_S) begin
				a_s4 <= gcd_pkg::ONE_Q30;
			end else begin
				a_s4 <= sum[A_W-1:0];
			end
		end
	end

	assign out_valid = vld_s[3];
	assign a         = a_s4;

endmodule

>>> hw/rtl/gcd_isqrt.sv
// Pipelined floor square root of op * 2^30, one result bit per stage.
// Depends on gcd_pkg and the assertion macro header.
`include "great_circle_distance_defines.svh"

module gcd_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [gcd_pkg::A_W-1:0] op,
	output logic                    out_valid,
	output logic [gcd_pkg::A_W-1:0] root
);
	localparam int N = gcd_pkg::SQRT_STEPS;
	localparam int W = gcd_pkg::SQ_W;

	logic [N-1:0] vld_s;
	logic [W-1:0] v_s [N];
	logic [W-1:0] r_s [N];
	logic [W-1:0] rem_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam int K = N - 1 - j;
		localparam logic [W-1:0] BIT = W'(1) << (2 * K);
		logic [W-1:0] v_in, r_in, trial;

		if (j == 0) begin : g_first
			assign v_in = W'(op) << 30;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[j-1];
			assign r_in = r_s[j-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_s[j] <= v_in - trial;
					r_s[j] <= (r_in >> 1) + BIT;
				end else begin
					v_s[j] <= v_in;
					r_s[j] <= r_in >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root      = r_s[N-1][gcd_pkg::A_W-1:0];
	assign rem_lim   = r_s[N-1] << 1;

	// floor root: remainder never exceeds twice the root
	`GCD_ASSERT_IMPL(a_sqrt_rem, out_valid, v_s[N-1] <= rem_lim, "isqrt remainder too large")

endmodule

>>> hw/rtl/gcd_cordic_vec.sv
// Pipelined vectoring-mode CORDIC: angle of (x, y) for x, y >= 0, Q2.30.
// Depends on gcd_pkg and the assertion macro header.
`include "great_circle_distance_defines.svh"

module gcd_cordic_vec (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [gcd_pkg::A_W-1:0] y0,
	input  logic [gcd_pkg::A_W-1:0] x0,
	output logic                    out_valid,
	output gcd_pkg::ang_t           angle
);
	localparam int N     = gcd_pkg::CORDIC_STAGES;
	localparam int ANG_W = gcd_pkg::ANG_W;

	logic [N-1:0]  vld_s;
	gcd_pkg::ang_t x_s [N];
	gcd_pkg::ang_t y_s [N];
	gcd_pkg::ang_t z_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam gcd_pkg::ang_t ATAN_I = ANG_W'({2'b00, gcd_pkg::ATAN_TAB[i]});
		gcd_pkg::ang_t x_in, y_in, z_in;

		if (i == 0) begin : g_first
			assign x_in = $signed(ANG_W'(x0));
			assign y_in = $signed(ANG_W'(y0));
			assign z_in = '0;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[ANG_W-1]) begin
					x_s[i] <= x_in + (y_in >>> i);
					y_s[i] <= y_in - (x_in >>> i);
					z_s[i] <= z_in + ATAN_I;
				end else begin
					x_s[i] <= x_in - (y_in >>> i);
					y_s[i] <= y_in + (x_in >>> i);
					z_s[i] <= z_in - ATAN_I;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign angle     = z_s[N-1];

	// first-quadrant input: x only grows
	`GCD_ASSERT_IMPL(a_vec_x_pos, out_valid, !x_s[N-1][ANG_W-1], "vectoring x went negative")

endmodule
